### hw/rtl/fpsp_pkg.sv
// shared types and constants of the frame pixel statistics probe
package fpsp_pkg;

    // channel and register widths
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned NCHAN   = 3;
    localparam int unsigned LIMIT_W = 9;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = LIMIT_W;

    // channel difference above which a pixel no longer matches the clear color
    localparam logic [CHAN_W-1:0] TOUCH_MARGIN = 8'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_DELTA  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_BLACK  = 3'd4;

    // input request
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              end_of_frame;
        logic              start_of_probe;
    } t_pixel;

    // result request
    typedef struct packed {
        logic [CHAN_W-1:0] low_red;
        logic [CHAN_W-1:0] low_green;
        logic [CHAN_W-1:0] low_blue;
        logic [CHAN_W-1:0] high_red;
        logic [CHAN_W-1:0] high_green;
        logic [CHAN_W-1:0] high_blue;
        logic [CHAN_W-1:0] spread;
        logic [CHAN_W-1:0] max_spread;
        logic              touched;
        logic              all_uniform;
        logic              time_varying;
        logic              near_black;
    } t_result;

    // configuration registers
    typedef struct packed {
        logic [NCHAN-1:0][CHAN_W-1:0] clear_color;
        logic [CHAN_W-1:0]            flat_delta;
        logic [LIMIT_W-1:0]           near_black_limit;
    } t_cfg;

    // probe state carried from pixel to pixel
    typedef struct packed {
        logic [NCHAN-1:0][CHAN_W-1:0] frame_low;
        logic [NCHAN-1:0][CHAN_W-1:0] frame_high;
        logic [NCHAN-1:0][CHAN_W-1:0] previous_low;
        logic [NCHAN-1:0][CHAN_W-1:0] previous_high;
        logic                         have_previous;
        logic                         touched_flag;
        logic                         uniform_flag;
        logic                         varying_flag;
        logic [CHAN_W-1:0]            largest_spread;
        logic [CHAN_W-1:0]            brightest_value;
    } t_state;

    localparam t_cfg CFG_RESET = '{
        clear_color:      {8'd255, 8'd0, 8'd255},
        flat_delta:       8'd2,
        near_black_limit: 9'd16
    };

    localparam t_state STATE_RESET = '{
        frame_low:       {NCHAN{8'hFF}},
        frame_high:      '0,
        previous_low:    {NCHAN{8'hFF}},
        previous_high:   '0,
        have_previous:   1'b0,
        touched_flag:    1'b0,
        uniform_flag:    1'b1,
        varying_flag:    1'b0,
        largest_spread:  '0,
        brightest_value: '0
    };

endpackage

### hw/rtl/fpsp_eval.sv
// per-pixel update of the probe state and frame-end result
module fpsp_eval (
    input  fpsp_pkg::t_pixel  i_pixel,
    input  fpsp_pkg::t_state  i_state,
    input  fpsp_pkg::t_cfg    i_cfg,
    output fpsp_pkg::t_state  o_state,
    output fpsp_pkg::t_result o_result
);
    import fpsp_pkg::*;

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    t_state                       base;
    t_state                       nxt;
    logic [NCHAN-1:0][CHAN_W-1:0] px;
    logic [NCHAN-1:0][CHAN_W-1:0] lo;
    logic [NCHAN-1:0][CHAN_W-1:0] hi;
    logic [CHAN_W-1:0]            spread;
    logic [CHAN_W-1:0]            bright;
    logic                         touched;
    logic                         changed;

    // channel order matches the clear color registers
    assign px = {i_pixel.red, i_pixel.green, i_pixel.blue};

    always_comb begin
        // start of probe clears everything before the pixel is taken
        base    = i_pixel.start_of_probe ? STATE_RESET : i_state;
        touched = base.touched_flag;
        spread  = '0;
        bright  = base.brightest_value;
        changed = 1'b0;

        // extremes of the frame in progress and clear color check
        for (int c = 0; c < NCHAN; c++) begin
            lo[c] = (px[c] < base.frame_low[c])  ? px[c] : base.frame_low[c];
            hi[c] = (px[c] > base.frame_high[c]) ? px[c] : base.frame_high[c];
            if (abs_diff(px[c], i_cfg.clear_color[c]) > TOUCH_MARGIN) begin
                touched = 1'b1;
            end
        end

        // frame-end figures
        for (int c = 0; c < NCHAN; c++) begin
            if ((hi[c] - lo[c]) > spread) begin
                spread = hi[c] - lo[c];
            end
            if (hi[c] > bright) begin
                bright = hi[c];
            end
            if ((abs_diff(hi[c], base.previous_high[c]) > i_cfg.flat_delta) ||
                (abs_diff(lo[c], base.previous_low[c]) > i_cfg.flat_delta)) begin
                changed = 1'b1;
            end
        end

        nxt              = base;
        nxt.frame_low    = lo;
        nxt.frame_high   = hi;
        nxt.touched_flag = touched;
        if (i_pixel.end_of_frame) begin
            if (spread > i_cfg.flat_delta) begin
                nxt.uniform_flag = 1'b0;
            end
            if (spread > base.largest_spread) begin
                nxt.largest_spread = spread;
            end
            if (base.have_previous && changed) begin
                nxt.varying_flag = 1'b1;
            end
            nxt.brightest_value = bright;
            nxt.previous_low    = lo;
            nxt.previous_high   = hi;
            nxt.have_previous   = 1'b1;
            nxt.frame_low       = STATE_RESET.frame_low;
            nxt.frame_high      = STATE_RESET.frame_high;
        end
    end

    assign o_state = nxt;

    // result fields of a frame-end pixel
    assign o_result = '{
        low_red:      lo[2],
        low_green:    lo[1],
        low_blue:     lo[0],
        high_red:     hi[2],
        high_green:   hi[1],
        high_blue:    hi[0],
        spread:       spread,
        max_spread:   nxt.largest_spread,
        touched:      nxt.touched_flag,
        all_uniform:  nxt.uniform_flag,
        time_varying: nxt.varying_flag,
        near_black:   ({1'b0, nxt.brightest_value} < i_cfg.near_black_limit)
    };

endmodule

### hw/rtl/frame_pixel_statistics_probe.sv
// top level of the frame pixel statistics probe
//
// Takes one RGB pixel per clock while the input register is not stalled and
// returns one result for each pixel marked end_of_frame. An accepted pixel
// sits in the input register until it advances; it is then folded into the
// probe state, and a frame-end result is loaded into the output register at
// that same edge. The rate is one pixel per clock while no stall occurs. The
// input register stalls only when it holds a frame-end pixel and the output
// register still holds a result not yet taken.
// Configuration registers are written through i_cfg_we/i_cfg_index/i_cfg_data
// while the probe is idle; the user must keep to this, as the block itself
// does not enforce it. Writes to unknown indexes are dropped.
module frame_pixel_statistics_probe (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  fpsp_pkg::t_pixel                    i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output fpsp_pkg::t_result                   o_out_data,
    input  logic                                i_cfg_we,
    input  logic [fpsp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fpsp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import fpsp_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_pixel  r_in;
    t_state  r_state;
    logic    r_out_valid;
    t_result r_out;
    t_state  n_state;
    t_result n_out;
    logic    advance;
    logic    out_free;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CLEAR_RED:   r_cfg.clear_color[2]   <= i_cfg_data[CHAN_W-1:0];
                CFG_CLEAR_GREEN: r_cfg.clear_color[1]   <= i_cfg_data[CHAN_W-1:0];
                CFG_CLEAR_BLUE:  r_cfg.clear_color[0]   <= i_cfg_data[CHAN_W-1:0];
                CFG_FLAT_DELTA:  r_cfg.flat_delta       <= i_cfg_data[CHAN_W-1:0];
                CFG_NEAR_BLACK:  r_cfg.near_black_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // a held pixel moves on unless it needs the output register and that is full
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (!r_in.end_of_frame || out_free);
    assign o_in_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // state update and result logic
    fpsp_eval u_eval (
        .i_pixel  (r_in),
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // probe state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && r_in.end_of_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && advance && r_in.end_of_frame) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
